@@ src/fpi_pkg.sv @@
package fpi_pkg;

    // command codes
    localparam logic [2:0] CMD_MOUSE    = 3'd0;
    localparam logic [2:0] CMD_KEY_DOWN = 3'd1;
    localparam logic [2:0] CMD_KEY_UP   = 3'd2;
    localparam logic [2:0] CMD_TICK     = 3'd3;
    localparam logic [2:0] CMD_SET_POS  = 3'd4;
    localparam logic [2:0] CMD_SET_HEAD = 3'd5;
    localparam logic [2:0] CMD_STOP     = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_SPEED = 2'd0;
    localparam logic [1:0] CFG_GAIN  = 2'd1;
    localparam logic [1:0] CFG_PITCH = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] SPEED_RESET = 16'd1280;
    localparam logic [15:0] GAIN_RESET  = 16'd4194;
    localparam logic [22:0] PITCH_RESET = 23'd2097152;

    // step selects
    localparam logic [1:0] STEP_SIN  = 2'd0;
    localparam logic [1:0] STEP_COS  = 2'd1;
    localparam logic [1:0] STEP_TILT = 2'd2;

    // axis selects
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [3:0] LAST_OP = 4'd9;

    // one saturating add of the movement sequence
    typedef struct packed {
        logic [1:0] dir;
        logic [1:0] axis;
        logic [1:0] step;
        logic       sub;
    } move_op_t;

    // forward, left, back, right groups in order
    function automatic move_op_t move_op(input logic [3:0] idx);
        move_op_t op;
        case (idx)
            4'd0:    op = '{dir: 2'd0, axis: AXIS_X, step: STEP_SIN,  sub: 1'b1};
            4'd1:    op = '{dir: 2'd0, axis: AXIS_Y, step: STEP_COS,  sub: 1'b0};
            4'd2:    op = '{dir: 2'd0, axis: AXIS_Z, step: STEP_TILT, sub: 1'b0};
            4'd3:    op = '{dir: 2'd1, axis: AXIS_X, step: STEP_COS,  sub: 1'b1};
            4'd4:    op = '{dir: 2'd1, axis: AXIS_Y, step: STEP_SIN,  sub: 1'b1};
            4'd5:    op = '{dir: 2'd2, axis: AXIS_X, step: STEP_SIN,  sub: 1'b0};
            4'd6:    op = '{dir: 2'd2, axis: AXIS_Y, step: STEP_COS,  sub: 1'b1};
            4'd7:    op = '{dir: 2'd2, axis: AXIS_Z, step: STEP_TILT, sub: 1'b1};
            4'd8:    op = '{dir: 2'd3, axis: AXIS_X, step: STEP_COS,  sub: 1'b0};
            4'd9:    op = '{dir: 2'd3, axis: AXIS_Y, step: STEP_SIN,  sub: 1'b0};
            default: op = '{dir: 2'd0, axis: AXIS_X, step: STEP_SIN,  sub: 1'b0};
        endcase
        return op;
    endfunction

endpackage

@@ src/free_look_pose_integrator.sv @@
// channel   direction  signals
// in        request    in_valid/in_ready, command, mouse_*, key_code, tick_length, new_*
// out       result     out_valid/out_ready, handled, moved, out_x/y/z, out_heading, out_tilt
// cfg       write      cfg_valid/cfg_ready, cfg_index, cfg_data
//
// one request at a time; a tick makes three table reads, each through the
// shared multiplier twice, then ten saturating adds through one adder. reset
// clears the pose, the held flags and the registers to their defaults. a
// result not taken holds the sequencer in its last state; cfg writes are
// always taken.
module free_look_pose_integrator #(
    parameter int ANGLE_BITS      = 24,
    parameter int TRIG_INDEX_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   command,
    input  logic signed [15:0]           mouse_dx,
    input  logic signed [15:0]           mouse_dy,
    input  logic [2:0]                   key_code,
    input  logic [15:0]                  tick_length,
    input  logic signed [31:0]           new_x,
    input  logic signed [31:0]           new_y,
    input  logic signed [31:0]           new_z,
    input  logic [ANGLE_BITS-1:0]        new_heading,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         handled,
    output logic                         moved,
    output logic signed [31:0]           out_x,
    output logic signed [31:0]           out_y,
    output logic signed [31:0]           out_z,
    output logic [ANGLE_BITS-1:0]        out_heading,
    output logic signed [ANGLE_BITS-1:0] out_tilt,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [22:0]                  cfg_data
);

    localparam int A       = ANGLE_BITS;
    localparam int T       = TRIG_INDEX_BITS;
    localparam int QBITS   = T - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam int WW      = 51;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MX   = 4'd1;
    localparam logic [3:0] S_MY   = 4'd2;
    localparam logic [3:0] S_MT   = 4'd3;
    localparam logic [3:0] S_ROM  = 4'd4;
    localparam logic [3:0] S_MUL1 = 4'd5;
    localparam logic [3:0] S_MUL2 = 4'd6;
    localparam logic [3:0] S_RND  = 4'd7;
    localparam logic [3:0] S_ADD  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]             state_reg;
    logic [15:0]            speed_reg;
    logic [15:0]            gain_reg;
    logic [22:0]            pitch_reg;
    logic [A-1:0]           heading_reg;
    logic signed [A-1:0]    tilt_reg;
    logic signed [31:0]     x_reg;
    logic signed [31:0]     y_reg;
    logic signed [31:0]     z_reg;
    logic [3:0]             held_reg;
    logic signed [15:0]     dx_reg;
    logic signed [15:0]     dy_reg;
    logic [15:0]            dt_reg;
    logic                   handled_reg;
    logic                   moved_reg;
    logic [1:0]             sel_reg;
    logic [3:0]             op_reg;
    logic                   neg_reg;
    logic signed [49:0]     prod_reg;
    logic signed [25:0]     d_reg [3];
    logic                   out_valid_reg;

    logic signed [32:0]     mul_a;
    logic signed [16:0]     mul_b;
    logic signed [49:0]     mul_p;
    logic [T-1:0]           heading_idx;
    logic [T-1:0]           tilt_idx;
    logic [T-1:0]           trig_idx;
    logic [QBITS:0]         rom_addr;
    logic [15:0]            rom_q;
    logic [47:0]            rnd_sum;
    logic signed [25:0]     step_val;
    logic [WW-1:0]          lim;
    logic signed [WW-1:0]   tilt_new;
    logic signed [WW-1:0]   tilt_clamped;
    fpi_pkg::move_op_t      op;
    logic signed [31:0]     coord_cur;
    logic signed [25:0]     d_cur;
    logic signed [33:0]     coord_sum;
    logic signed [31:0]     coord_sat;
    logic                   in_acc;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    // top table bits of each angle
    assign heading_idx = T'({heading_reg, {T{1'b0}}} >> A);
    assign tilt_idx    = T'({tilt_reg, {T{1'b0}}} >> A);

    // quarter-wave fold for the selected angle
    always_comb
    begin
        case (sel_reg)
            fpi_pkg::STEP_SIN: trig_idx = heading_idx;
            fpi_pkg::STEP_COS: trig_idx = heading_idx + T'(QUARTER);
            default:           trig_idx = tilt_idx;
        endcase
        if (trig_idx[T-2])
            rom_addr = (QBITS+1)'(QUARTER) - {1'b0, trig_idx[QBITS-1:0]};
        else
            rom_addr = {1'b0, trig_idx[QBITS-1:0]};
    end

    fpi_wave_rom #(
        .TRIG_INDEX_BITS(T)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_q)
    );

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_MX:
            begin
                mul_a = 33'(dx_reg);
                mul_b = {1'b0, gain_reg};
            end
            S_MY:
            begin
                mul_a = 33'(dy_reg);
                mul_b = {1'b0, gain_reg};
            end
            S_MUL1:
            begin
                mul_a = {17'd0, rom_q};
                mul_b = {1'b0, speed_reg};
            end
            default:
            begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = {1'b0, dt_reg};
            end
        endcase
        mul_p = 50'(mul_a * mul_b);
    end

    // rounding of a step magnitude
    assign rnd_sum  = prod_reg[47:0] + (48'd1 << 22);
    assign step_val = neg_reg ? -$signed({1'b0, rnd_sum[47:23]})
                              : $signed({1'b0, rnd_sum[47:23]});

    // tilt update with clamp
    always_comb
    begin
        if ({28'd0, pitch_reg} > (WW'(1) << (A - 2)))
            lim = WW'(1) << (A - 2);
        else
            lim = {28'd0, pitch_reg};
        tilt_new = WW'(tilt_reg) - WW'(prod_reg);
        if (tilt_new > $signed(lim))
            tilt_clamped = $signed(lim);
        else if (tilt_new < -$signed(lim))
            tilt_clamped = -$signed(lim);
        else
            tilt_clamped = tilt_new;
    end

    // shared saturating adder
    always_comb
    begin
        op = fpi_pkg::move_op(op_reg);
        case (op.axis)
            fpi_pkg::AXIS_X: coord_cur = x_reg;
            fpi_pkg::AXIS_Y: coord_cur = y_reg;
            default:         coord_cur = z_reg;
        endcase
        case (op.step)
            fpi_pkg::STEP_SIN: d_cur = d_reg[0];
            fpi_pkg::STEP_COS: d_cur = d_reg[1];
            default:           d_cur = d_reg[2];
        endcase
        if (op.sub)
            coord_sum = 34'(coord_cur) - 34'(d_cur);
        else
            coord_sum = 34'(coord_cur) + 34'(d_cur);
        if (coord_sum > 34'sh0_7FFF_FFFF)
            coord_sat = 32'sh7FFF_FFFF;
        else if (coord_sum < -34'sh0_8000_0000)
            coord_sat = 32'sh8000_0000;
        else
            coord_sat = coord_sum[31:0];
    end

    // sequencer and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            speed_reg     <= fpi_pkg::SPEED_RESET;
            gain_reg      <= fpi_pkg::GAIN_RESET;
            pitch_reg     <= fpi_pkg::PITCH_RESET;
            heading_reg   <= '0;
            tilt_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            held_reg      <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dt_reg        <= '0;
            handled_reg   <= 1'b0;
            moved_reg     <= 1'b0;
            sel_reg       <= '0;
            op_reg        <= '0;
            neg_reg       <= 1'b0;
            prod_reg      <= '0;
            d_reg[0]      <= '0;
            d_reg[1]      <= '0;
            d_reg[2]      <= '0;
            out_valid_reg <= 1'b0;
            handled       <= 1'b0;
            moved         <= 1'b0;
            out_x         <= '0;
            out_y         <= '0;
            out_z         <= '0;
            out_heading   <= '0;
            out_tilt      <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    fpi_pkg::CFG_SPEED: speed_reg <= cfg_data[15:0];
                    fpi_pkg::CFG_GAIN:  gain_reg  <= cfg_data[15:0];
                    fpi_pkg::CFG_PITCH: pitch_reg <= cfg_data;
                    default:            ;
                endcase
            end

            // result register handshake
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        dx_reg    <= mouse_dx;
                        dy_reg    <= mouse_dy;
                        dt_reg    <= tick_length;
                        sel_reg   <= fpi_pkg::STEP_SIN;
                        op_reg    <= '0;
                        moved_reg <= (command == fpi_pkg::CMD_TICK) && (|held_reg);
                        case (command)
                            fpi_pkg::CMD_MOUSE:
                            begin
                                handled_reg <= 1'b1;
                                state_reg   <= S_MX;
                            end
                            fpi_pkg::CMD_KEY_DOWN:
                            begin
                                handled_reg <= !key_code[2];
                                state_reg   <= S_DONE;
                                if (!key_code[2])
                                    held_reg[key_code[1:0]] <= 1'b1;
                            end
                            fpi_pkg::CMD_KEY_UP:
                            begin
                                handled_reg <= !key_code[2];
                                state_reg   <= S_DONE;
                                if (!key_code[2])
                                    held_reg[key_code[1:0]] <= 1'b0;
                            end
                            fpi_pkg::CMD_TICK:
                            begin
                                handled_reg <= 1'b1;
                                state_reg   <= S_ROM;
                            end
                            fpi_pkg::CMD_SET_POS:
                            begin
                                handled_reg <= 1'b1;
                                state_reg   <= S_DONE;
                                x_reg       <= new_x;
                                y_reg       <= new_y;
                                z_reg       <= new_z;
                            end
                            fpi_pkg::CMD_SET_HEAD:
                            begin
                                handled_reg <= 1'b1;
                                state_reg   <= S_DONE;
                                heading_reg <= new_heading;
                            end
                            fpi_pkg::CMD_STOP:
                            begin
                                handled_reg <= 1'b1;
                                state_reg   <= S_DONE;
                                held_reg    <= '0;
                            end
                            default:
                            begin
                                handled_reg <= 1'b0;
                                state_reg   <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MX:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MY;
                end
                S_MY:
                begin
                    heading_reg <= heading_reg - prod_reg[A-1:0];
                    prod_reg    <= mul_p;
                    state_reg   <= S_MT;
                end
                S_MT:
                begin
                    tilt_reg  <= tilt_clamped[A-1:0];
                    state_reg <= S_DONE;
                end
                S_ROM:
                begin
                    neg_reg   <= trig_idx[T-1];
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    d_reg[sel_reg] <= step_val;
                    sel_reg        <= sel_reg + 2'd1;
                    if (sel_reg == fpi_pkg::STEP_TILT)
                        state_reg <= S_ADD;
                    else
                        state_reg <= S_ROM;
                end
                S_ADD:
                begin
                    if (held_reg[op.dir])
                    begin
                        case (op.axis)
                            fpi_pkg::AXIS_X: x_reg <= coord_sat;
                            fpi_pkg::AXIS_Y: y_reg <= coord_sat;
                            default:         z_reg <= coord_sat;
                        endcase
                    end
                    op_reg <= op_reg + 4'd1;
                    if (op_reg == fpi_pkg::LAST_OP)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        handled     <= handled_reg;
                        moved       <= moved_reg;
                        out_x       <= x_reg;
                        out_y       <= y_reg;
                        out_z       <= z_reg;
                        out_heading <= heading_reg;
                        out_tilt    <= tilt_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/fpi_wave_rom.sv @@
module fpi_wave_rom #(
    parameter int TRIG_INDEX_BITS = 12
) (
    input  logic                       clk,
    input  logic [TRIG_INDEX_BITS-2:0] addr,
    output logic [15:0]                data
);

    localparam int QBITS   = TRIG_INDEX_BITS - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // rounded-up reciprocals of the series denominators, scaled by 2^64
    localparam logic [127:0] ONE_64 = 128'd1 << 64;
    localparam logic [127:0] RCP_1  = (ONE_64 + 128'd5) / 128'd6;
    localparam logic [127:0] RCP_2  = (ONE_64 + 128'd19) / 128'd20;
    localparam logic [127:0] RCP_3  = (ONE_64 + 128'd41) / 128'd42;
    localparam logic [127:0] RCP_4  = (ONE_64 + 128'd71) / 128'd72;
    localparam logic [127:0] RCP_5  = (ONE_64 + 128'd109) / 128'd110;
    localparam logic [127:0] RCP_6  = (ONE_64 + 128'd155) / 128'd156;
    localparam logic [127:0] RCP_7  = (ONE_64 + 128'd209) / 128'd210;
    localparam logic [127:0] RCP_8  = (ONE_64 + 128'd271) / 128'd272;

    typedef logic [15:0] wave_t [0:QUARTER];

    // quarter wave in Q1.15 from a Q30 Taylor series
    function automatic wave_t build_wave();
        wave_t w;
        longint unsigned x;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned v;
        logic [127:0] rcp;
        logic [127:0] prod;
        for (int j = 0; j <= QUARTER; j++)
        begin
            x = (longint'(j) * HALF_PI_Q30 + 64'(QUARTER >> 1)) >> QBITS;
            sum = x;
            term = x;
            for (int n = 1; n <= 8; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                case (n)
                    1:       rcp = RCP_1;
                    2:       rcp = RCP_2;
                    3:       rcp = RCP_3;
                    4:       rcp = RCP_4;
                    5:       rcp = RCP_5;
                    6:       rcp = RCP_6;
                    7:       rcp = RCP_7;
                    default: rcp = RCP_8;
                endcase
                // exact quotient for dividends far below 2^56
                prod = {64'd0, term} * rcp;
                term = prod[127:64];
                if ((n & 1) == 1)
                    sum = (sum >= term) ? sum - term : 64'd0;
                else
                    sum = sum + term;
            end
            v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767)
                v = 64'd32767;
            w[j] = v[15:0];
        end
        return w;
    endfunction

    localparam wave_t WAVE = build_wave();

    // registered read
    always_ff @(posedge clk)
    begin
        data <= WAVE[addr];
    end

endmodule
